>>> src/ifg_pkg.sv
// package for the image forward gradient block
// register indexes, field widths, reset values and parameter defaults
`timescale 1ns / 1ps

package ifg_pkg;

  localparam int MAX_ROWS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ROWS_CFG_W   = 11;
  localparam int COLS_W       = 16;
  localparam int PLANES_CFG_W = 5;
  localparam int PLANE_W      = 4;
  localparam int MAX_PLANES   = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [ROWS_CFG_W-1:0]   ROWS_RESET   = 11'd1024;
  localparam logic [COLS_W-1:0]       COLS_RESET   = 16'd1024;
  localparam logic [PLANES_CFG_W-1:0] PLANES_RESET = 5'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_PLANES  = 2'd2
  } cfg_reg_t;

endpackage

>>> src/ifg_store.sv
// line store of held samples: two copies so three slots can be read per cycle
// one write port, registered reads with same-cycle write forwarding; no package use
`timescale 1ns / 1ps

module ifg_store #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [DATA_W-1:0] wd,
  input  logic              re,
  input  logic [ADDR_W-1:0] ra_here,
  input  logic [ADDR_W-1:0] ra_below,
  input  logic [ADDR_W-1:0] ra_right,
  output logic [DATA_W-1:0] here,
  output logic [DATA_W-1:0] below,
  output logic [DATA_W-1:0] right
);

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  logic [DATA_W-1:0] rd_here;
  logic [DATA_W-1:0] rd_below;
  logic [DATA_W-1:0] rd_right;
  logic [DATA_W-1:0] fwd_data;
  logic              hit_here;
  logic              hit_below;
  logic              hit_right;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[wa] <= wd;
      mem_b[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_here   <= mem_a[ra_here];
      rd_below  <= mem_a[ra_below];
      rd_right  <= mem_b[ra_right];
      fwd_data  <= wd;
      hit_here  <= we && (ra_here == wa);
      hit_below <= we && (ra_below == wa);
      hit_right <= we && (ra_right == wa);
    end
  end

  assign here  = hit_here  ? fwd_data : rd_here;
  assign below = hit_below ? fwd_data : rd_below;
  assign right = hit_right ? fwd_data : rd_right;

endmodule

>>> src/image_forward_gradient_top.sv
// image forward gradient: column-major samples in, two forward differences out
// result valid after the input transfer passes the store read register, then the result register
// one item per cycle sustained while results are taken; a pixel is answered rows_in_use items later
// reset (synchronous) empties the line store and pipeline, zeroes the position
// counters and loads 1024 rows, 1024 columns, 3 planes; no clearing pass is needed
`timescale 1ns / 1ps

module image_forward_gradient_top
  import ifg_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          action,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS:0]   diff_across_columns,
  output logic signed [SAMPLE_BITS:0]   diff_down_rows,
  output logic                          plane_done,
  output logic                          image_done
);

  localparam int DEPTH = MAX_ROWS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  function automatic logic [CW-1:0] clamp_rows(input logic [ROWS_CFG_W-1:0] v);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return CW'(r);
  endfunction

  function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_W-1:0] v);
    return (v == '0) ? COLS_W'(1) : v;
  endfunction

  function automatic logic [PLANES_CFG_W-1:0] clamp_planes(
    input logic [PLANES_CFG_W-1:0] v
  );
    logic [PLANES_CFG_W-1:0] r;
    r = v;
    if (v == '0) r = PLANES_CFG_W'(1);
    if (v > PLANES_CFG_W'(MAX_PLANES)) r = PLANES_CFG_W'(MAX_PLANES);
    return r;
  endfunction

  // effective register values
  logic [CW-1:0]           rows_eff;
  logic [COLS_W-1:0]       cols_eff;
  logic [PLANES_CFG_W-1:0] planes_eff;

  // stream state
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      pending;
  logic [RIW-1:0]     out_row;
  logic [COLS_W-1:0]  out_column;
  logic [PLANE_W-1:0] out_plane;

  logic [AW-1:0]      head_next;
  logic [AW-1:0]      tail_next;
  logic [CW-1:0]      pending_next;
  logic [RIW-1:0]     out_row_next;
  logic [COLS_W-1:0]  out_column_next;
  logic [PLANE_W-1:0] out_plane_next;

  // stage 1 and result register
  logic s1_valid;
  logic s1_use_across;
  logic s1_use_down;
  logic s1_plane_done;
  logic s1_image_done;
  logic out_en;
  logic advance;
  logic accept;

  logic          pixel;
  logic [CW-1:0] pend_inc;
  logic [CW-1:0] pend_cur;
  logic          emit;
  logic          last_row;
  logic          last_col;
  logic          last_plane;
  logic          use_across;
  logic          use_down;

  logic [AW-1:0] tail_inc;
  logic [AW:0]   right_sum;
  logic [AW:0]   right_wrap;
  logic [AW-1:0] right_addr;

  logic [SAMPLE_BITS-1:0] st_here;
  logic [SAMPLE_BITS-1:0] st_below;
  logic [SAMPLE_BITS-1:0] st_right;
  logic signed [SAMPLE_BITS:0] ext_here;
  logic signed [SAMPLE_BITS:0] ext_below;
  logic signed [SAMPLE_BITS:0] ext_right;

  assign cfg_ready  = 1'b1;
  assign out_en     = !result_valid || result_ready;
  assign advance    = !s1_valid || out_en;
  assign item_ready = advance;
  assign accept     = item_valid && item_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_eff   <= clamp_rows(ROWS_RESET);
      cols_eff   <= clamp_cols(COLS_RESET);
      planes_eff <= clamp_planes(PLANES_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS:    rows_eff   <= clamp_rows(cfg_data[ROWS_CFG_W-1:0]);
        CFG_COLUMNS: cols_eff   <= clamp_cols(cfg_data[COLS_W-1:0]);
        CFG_PLANES:  planes_eff <= clamp_planes(cfg_data[PLANES_CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  // item decode and position
  always_comb begin
    pixel      = (action == 1'b0);
    pend_inc   = pending + 1'b1;
    pend_cur   = pixel ? pend_inc : pending;
    emit       = pixel ? (pend_inc > rows_eff) : (pending != '0);
    last_row   = ((CW + 1)'(out_row) + 1'b1) >= (CW + 1)'(rows_eff);
    last_col   = ((COLS_W + 1)'(out_column) + 1'b1) >= (COLS_W + 1)'(cols_eff);
    last_plane = ((PLANES_CFG_W + 1)'(out_plane) + 1'b1) >= (PLANES_CFG_W + 1)'(planes_eff);
    use_across = !last_col && (pend_cur > rows_eff);
    use_down   = !last_row && (pend_cur >= CW'(2));
  end

  // ring addresses
  always_comb begin
    tail_inc   = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
    right_sum  = (AW + 1)'(tail) + (AW + 1)'(rows_eff);
    right_wrap = (right_sum >= (AW + 1)'(DEPTH)) ? right_sum - (AW + 1)'(DEPTH)
                                                 : right_sum;
    right_addr = right_wrap[AW-1:0];
  end

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    pending_next    = pending;
    out_row_next    = out_row;
    out_column_next = out_column;
    out_plane_next  = out_plane;
    if (accept) begin
      if (pixel) begin
        head_next = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      pending_next = emit ? pend_cur - 1'b1 : pend_cur;
      if (emit) begin
        tail_next = tail_inc;
        if (!last_row) begin
          out_row_next = out_row + 1'b1;
        end else begin
          out_row_next = '0;
          if (!last_col) begin
            out_column_next = out_column + 1'b1;
          end else begin
            out_column_next = '0;
            out_plane_next  = last_plane ? '0 : out_plane + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      pending    <= '0;
      out_row    <= '0;
      out_column <= '0;
      out_plane  <= '0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      pending    <= pending_next;
      out_row    <= out_row_next;
      out_column <= out_column_next;
      out_plane  <= out_plane_next;
    end
  end

  ifg_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (SAMPLE_BITS)
  ) u_store (
    .clk      (clk),
    .we       (accept && pixel),
    .wa       (head),
    .wd       (sample),
    .re       (advance),
    .ra_here  (tail),
    .ra_below (tail_inc),
    .ra_right (right_addr),
    .here     (st_here),
    .below    (st_below),
    .right    (st_right)
  );

  // stage 1 flags, loaded with the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_use_across <= use_across;
      s1_use_down   <= use_down;
      s1_plane_done <= last_row && last_col;
      s1_image_done <= last_row && last_col && last_plane;
    end
  end

  // differences
  assign ext_here  = {st_here[SAMPLE_BITS-1], st_here};
  assign ext_below = {st_below[SAMPLE_BITS-1], st_below};
  assign ext_right = {st_right[SAMPLE_BITS-1], st_right};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      diff_across_columns <= s1_use_across ? ext_right - ext_here : '0;
      diff_down_rows      <= s1_use_down ? ext_below - ext_here : '0;
      plane_done          <= s1_plane_done;
      image_done          <= s1_image_done;
    end
  end

endmodule
